// ===== rtl/core/pixel_colour_temperature_macros.svh =====
// Assertion macros for the colour temperature RTL.
`ifndef PIXEL_COLOUR_TEMPERATURE_MACROS_SVH
`define PIXEL_COLOUR_TEMPERATURE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at each rising edge, ignored while reset is held.
`define PCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every rising edge, reset included.
`define PCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pct_pkg.sv =====
// Types, constants and the sRGB linearisation table for the colour temperature block.
`default_nettype none
package pct_pkg;

    localparam int FRAC_BITS_DEF = 4;
    // Quotient bits of n in Q.16; anything at or above 2^26 saturates anyway
    localparam int QBITS = 26;
    localparam int DEN_W = 30;
    localparam int U_W   = 47;
    localparam int M_W   = QBITS + 1;
    localparam logic [QBITS-1:0] N_BOUND_Q16 = QBITS'(768 * 65536);
    localparam logic signed [35:0] A1_K = 36'sd231014400;   // 3525 in Q.16
    localparam logic signed [47:0] C1_Q16 = 48'sd447171789;  // 6823.3 in Q.16
    localparam logic signed [57:0] C0_Q16 = 58'sd361780347;  // 5520.33 in Q.16

    typedef struct packed {
        logic black;
        logic sat;
        logic sat_neg;
        logic last;
    } t_side;

    typedef struct packed {
        logic signed [31:0] cct;
        logic               black;
        logic               sat;
        logic               last;
    } t_res;

    // One entry of the sRGB decode curve in Q0.16, exact rounding
    function automatic logic [15:0] lin_entry(input int unsigned c);
        logic [383:0] k;
        logic [383:0] r;
        logic [383:0] t;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        int           i;
        int           j;
        if (c * 100000 <= 1031475) begin
            return 16'((655360 * c + 16473) / 32946);
        end
        k = 384'd1;
        r = 384'd1;
        for (i = 0; i < 12; i++) begin
            k = k * 384'd269025;
            r = r * 384'(1000 * c + 14025);
        end
        r = r << 85;
        lo = 17'd0;
        hi = 17'd65536;
        // Largest lo with lo - 0.5 <= 65536 * v^2.4, tested in fifth powers
        for (j = 0; j < 20; j++) begin
            if (lo < hi) begin
                mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
                t = k;
                for (i = 0; i < 5; i++) begin
                    t = t * (384'(mid) * 384'd2 - 384'd1);
                end
                if (t <= r) begin
                    lo = mid;
                end else begin
                    hi = mid - 17'd1;
                end
            end
        end
        return (lo > 17'd65535) ? 16'hFFFF : lo[15:0];
    endfunction

    function automatic logic [255:0][15:0] build_rom();
        logic [255:0][15:0] rom;
        for (int c = 0; c < 256; c++) begin
            rom[c] = lin_entry(c);
        end
        return rom;
    endfunction

    localparam logic [255:0][15:0] LIN_ROM = build_rom();

endpackage
`default_nettype wire

// ===== rtl/core/pct_front.sv =====
// Front stages: linearise, matrix to XYZ, form num/den, prepare the divide.
`default_nettype none
module pct_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [7:0]                i_red,
    input  wire logic [7:0]                i_green,
    input  wire logic [7:0]                i_blue,
    input  wire logic                      i_last,
    output logic                           o_valid,
    output logic [pct_pkg::U_W-1:0]        o_rem,
    output logic [pct_pkg::DEN_W-1:0]      o_den,
    output logic                           o_neg,
    output pct_pkg::t_side                 o_side
);
    import pct_pkg::*;

    logic [3:0]  r_v;
    logic [2:0]  r_last;
    logic [15:0] r_lin_r, r_lin_g, r_lin_b;
    logic [16:0] r_x, r_y, r_z;
    logic signed [31:0] r_num, r_den;
    logic        r_black;
    logic [U_W-1:0]   r_rem;
    logic [DEN_W-1:0] r_dabs;
    logic        r_neg;
    t_side       r_side;

    logic [31:0] n_xs, n_ys, n_zs;
    logic [17:0] n_d;
    logic signed [31:0] n_num, n_den;
    logic        n_dneg;
    logic signed [31:0] n_nums, n_dabs;
    logic signed [47:0] n_big;
    t_side       n_side;

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Look up the linear value of each channel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin_r   <= LIN_ROM[i_red];
            r_lin_g   <= LIN_ROM[i_green];
            r_lin_b   <= LIN_ROM[i_blue];
            r_last[0] <= i_last;
        end
    end

    // Matrix to XYZ in Q1.16 with rounding
    always_comb begin
        n_xs = 32'd13514 * 32'(r_lin_r) + 32'd11718 * 32'(r_lin_g)
             + 32'd5915 * 32'(r_lin_b) + 32'd16384;
        n_ys = 32'd6966 * 32'(r_lin_r) + 32'd23436 * 32'(r_lin_g)
             + 32'd2366 * 32'(r_lin_b) + 32'd16384;
        n_zs = 32'd632 * 32'(r_lin_r) + 32'd3906 * 32'(r_lin_g)
             + 32'd31146 * 32'(r_lin_b) + 32'd16384;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x       <= n_xs[31:15];
            r_y       <= n_ys[31:15];
            r_z       <= n_zs[31:15];
            r_last[1] <= r_last[0];
        end
    end

    // Chromaticity numerator and denominator
    always_comb begin
        n_d   = 18'(r_x) + 18'(r_y) + 18'(r_z);
        n_num = $signed(32'd10000 * 32'(r_x) - 32'd3320 * 32'(n_d));
        n_den = $signed(32'd1858 * 32'(n_d) - 32'd10000 * 32'(r_y));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num     <= n_num;
            r_den     <= n_den;
            r_black   <= (n_d == 18'd0);
            r_last[2] <= r_last[1];
        end
    end

    // Make the divisor positive and fold the floor into a magnitude
    always_comb begin
        n_dneg = r_den[31];
        n_nums = n_dneg ? -r_num : r_num;
        n_dabs = n_dneg ? -r_den : r_den;
        n_big  = $signed({n_nums, 16'd0}) + $signed({18'd0, n_dabs[DEN_W:1]});
        n_side.black   = r_black;
        n_side.sat     = !r_black && (r_den == 32'sd0);
        n_side.sat_neg = r_num[31];
        n_side.last    = r_last[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_big[47] ? ~n_big[U_W-1:0] : n_big[U_W-1:0];
            r_dabs <= n_dabs[DEN_W-1:0];
            r_neg  <= n_big[47];
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[3];
    assign o_rem   = r_rem;
    assign o_den   = r_dabs;
    assign o_neg   = r_neg;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// ===== rtl/core/pct_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pct_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [pct_pkg::U_W-1:0]   i_rem,
    input  wire logic [pct_pkg::DEN_W-1:0] i_den,
    input  wire logic                      i_neg,
    input  wire pct_pkg::t_side            i_side,
    output logic                           o_valid,
    output logic [pct_pkg::QBITS-1:0]      o_q,
    output logic                           o_neg,
    output pct_pkg::t_side                 o_side
);
    import pct_pkg::*;

    localparam int SH_W = DEN_W + QBITS;

    logic [QBITS-1:0] r_v;
    logic [U_W-1:0]   r_rem  [QBITS];
    logic [DEN_W-1:0] r_den  [QBITS];
    logic [QBITS-1:0] r_q    [QBITS];
    logic [QBITS-1:0] r_neg;
    t_side            r_side [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        localparam int B = QBITS - 1 - k;

        logic             in_v;
        logic [U_W-1:0]   in_rem;
        logic [DEN_W-1:0] in_den;
        logic [QBITS-1:0] in_q;
        logic             in_neg;
        t_side            in_side;
        logic [SH_W-1:0]  sh;
        logic             ge;
        t_side            n_side;

        if (k == 0) begin : g_first
            logic ovf;
            assign in_v   = i_valid;
            assign in_rem = i_rem;
            assign in_den = i_den;
            assign in_q   = '0;
            assign in_neg = i_neg;
            // Quotient of 2^26 or more is certain saturation
            assign ovf    = SH_W'(i_rem) >= (SH_W'(i_den) << QBITS);
            always_comb begin
                in_side = i_side;
                if (ovf && !i_side.black && !i_side.sat) begin
                    in_side.sat     = 1'b1;
                    in_side.sat_neg = i_neg;
                end
            end
        end else begin : g_next
            assign in_v    = r_v[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_den  = r_den[k-1];
            assign in_q    = r_q[k-1];
            assign in_neg  = r_neg[k-1];
            assign in_side = r_side[k-1];
        end

        // Trial subtract of the shifted divisor
        assign sh     = SH_W'(in_den) << B;
        assign ge     = SH_W'(in_rem) >= sh;
        assign n_side = in_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? in_rem - sh[U_W-1:0] : in_rem;
                r_q[k]    <= in_q | (QBITS'(ge) << B);
                r_den[k]  <= in_den;
                r_neg[k]  <= in_neg;
                r_side[k] <= n_side;
            end
        end
    end

    assign o_valid = r_v[QBITS-1];
    assign o_q     = r_q[QBITS-1];
    assign o_neg   = r_neg[QBITS-1];
    assign o_side  = r_side[QBITS-1];

endmodule
`default_nettype wire

// ===== rtl/core/pct_cubic.sv =====
// McCamy cubic in Horner form, rounding and clipping of the result.
`default_nettype none
module pct_cubic #(
    parameter int FRAC_BITS = pct_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [pct_pkg::QBITS-1:0] i_q,
    input  wire logic                      i_neg,
    input  wire pct_pkg::t_side            i_side,
    output logic                           o_valid,
    output pct_pkg::t_res                  o_res
);
    import pct_pkg::*;

    localparam int SH = 16 - FRAC_BITS;
    localparam logic signed [57:0] HALF =
        (SH > 0) ? (58'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : 58'sd0;
    localparam logic signed [57:0] RES_MAX = 58'sd2147483647;
    localparam logic signed [57:0] RES_MIN = -58'sd2147483648;

    logic [5:0]          r_v;
    t_side               r_sd [5];
    logic signed [M_W-1:0] r_m0, r_m1, r_m2;
    logic signed [35:0]  r_a1;
    logic signed [63:0]  r_p1;
    logic signed [39:0]  r_t;
    logic signed [65:0]  r_p2;
    logic signed [57:0]  r_a3;
    t_res                r_res;

    logic signed [M_W-1:0] n_m;
    logic                n_big;
    t_side               n_sd0;
    logic signed [47:0]  n_a2;
    logic signed [57:0]  n_rnd;
    t_res                n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Restore the signed floor quotient and check the range bound
    always_comb begin
        n_m   = i_neg ? ~$signed({1'b0, i_q}) : $signed({1'b0, i_q});
        n_big = i_neg ? (i_q >= N_BOUND_Q16 - QBITS'(1)) : (i_q >= N_BOUND_Q16);
        n_sd0 = i_side;
        if (n_big && !i_side.black && !i_side.sat) begin
            n_sd0.sat     = 1'b1;
            n_sd0.sat_neg = i_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0    <= n_m;
            r_a1    <= 36'(n_m) * 36'sd449 + A1_K;
            r_sd[0] <= n_sd0;
        end
    end

    // First Horner product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= 64'(r_a1) * 64'(r_m0);
            r_m1    <= r_m0;
            r_sd[1] <= r_sd[0];
        end
    end

    // Round back to Q.16, add the linear term, drop eight bits
    assign n_a2 = 48'((r_p1 + 64'sd32768) >>> 16) + C1_Q16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= 40'((n_a2 + 48'sd128) >>> 8);
            r_m2    <= r_m1;
            r_sd[2] <= r_sd[1];
        end
    end

    // Second Horner product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2    <= 66'(r_t) * 66'(r_m2);
            r_sd[3] <= r_sd[2];
        end
    end

    // Add the constant term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a3    <= 58'((r_p2 + 66'sd128) >>> 8) + C0_Q16;
            r_sd[4] <= r_sd[3];
        end
    end

    // Round to the output fraction, clip, apply the special cases
    always_comb begin
        n_rnd      = (r_a3 + HALF) >>> SH;
        n_res.last = r_sd[4].last;
        n_res.black = r_sd[4].black;
        priority if (r_sd[4].black) begin
            n_res.cct = 32'sd0;
            n_res.sat = 1'b0;
        end else if (r_sd[4].sat) begin
            n_res.cct = r_sd[4].sat_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            n_res.sat = 1'b1;
        end else if (n_rnd > RES_MAX) begin
            n_res.cct = 32'sh7FFFFFFF;
            n_res.sat = 1'b1;
        end else if (n_rnd < RES_MIN) begin
            n_res.cct = 32'sh80000000;
            n_res.sat = 1'b1;
        end else begin
            n_res.cct = n_rnd[31:0];
            n_res.sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v[5];
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/pixel_colour_temperature.sv =====
// Top level of the pixel colour temperature block with its output skid buffer.
// Takes one 8-bit sRGB pixel per clock and returns its correlated colour temperature
// (McCamy), signed Kelvin with FRAC_BITS fraction bits, in the same order. Throughput
// is one pixel per clock; an input transfer loads the first of 37 register stages: 4
// front stages, 26 stages of the restoring divider that forms n (one quotient bit per
// stage, which sets the depth), 6 cubic stages and the output register. A stalled
// output freezes the pipeline once the skid register fills; input is taken until then.
// tuser bit 0 flags a black pixel (result 0), bit 1 a zero divisor or clipped result.
`default_nettype none
`include "pixel_colour_temperature_macros.svh"
module pixel_colour_temperature #(
    parameter int FRAC_BITS = pct_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire logic        i_s_tlast,  // last_pixel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,  // cct_kelvin [31:0]
    output logic [1:0]       o_m_tuser,  // black_pixel [0], saturated [1]
    output logic             o_m_tlast   // last_out
);
    import pct_pkg::*;

    logic             en;
    logic             f_valid;
    logic [U_W-1:0]   f_rem;
    logic [DEN_W-1:0] f_den;
    logic             f_neg;
    t_side            f_side;
    logic             d_valid;
    logic [QBITS-1:0] d_q;
    logic             d_neg;
    t_side            d_side;
    logic             c_valid;
    t_res             c_res;

    logic             r_o_v;
    logic             r_skid_v;
    t_res             r_o;
    t_res             r_skid;
    logic             take;

    // Freeze the pipeline only while the skid register holds a transfer
    assign en         = !r_skid_v;
    assign o_s_tready = en;

    pct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .i_last  (i_s_tlast),
        .o_valid (f_valid),
        .o_rem   (f_rem),
        .o_den   (f_den),
        .o_neg   (f_neg),
        .o_side  (f_side)
    );

    pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rem   (f_rem),
        .i_den   (f_den),
        .i_neg   (f_neg),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_neg   (d_neg),
        .o_side  (d_side)
    );

    pct_cubic #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_q     (d_q),
        .i_neg   (d_neg),
        .i_side  (d_side),
        .o_valid (c_valid),
        .o_res   (c_res)
    );

    assign take = r_o_v && i_m_tready;

    // Output register and skid: refill from skid first, else from the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (c_valid) begin
            if (!r_o_v || take) begin
                r_o_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_o <= r_skid;
            end
        end else if (c_valid) begin
            if (!r_o_v || take) begin
                r_o <= c_res;
            end else begin
                r_skid <= c_res;
            end
        end
    end

    assign o_m_tvalid   = r_o_v;
    assign o_m_tdata    = r_o.cct;
    assign o_m_tuser[0] = r_o.black;
    assign o_m_tuser[1] = r_o.sat;
    assign o_m_tlast    = r_o.last;

    `PCT_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_v |-> r_o_v, "skid full with output empty")
    `PCT_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_v) |-> $past(r_o_v && !i_m_tready), "skid filled without a stall")
    `PCT_ASSERT(a_black_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 32'd0 && !o_m_tuser[1], "black pixel with nonzero result")
    `PCT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid && !r_skid_v, "output not empty after reset")

endmodule
`default_nettype wire
